### rtl/core/krt_pkg.sv
package krt_pkg;

  // Fixed widths of the transfer fields on the top-level ports.
  localparam int unsigned KindW    = 2;
  localparam int unsigned IdPortW  = 16;
  localparam int unsigned PayPortW = 64;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CountW   = 5;

  typedef enum logic [KindW-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_FIND   = 2'd2
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE      = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_REJECTED  = 2'd3
  } status_e;

endpackage

### rtl/core/krt_mem.sv
module krt_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned IdW   = 16,
  parameter int unsigned PayW  = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [IdW-1:0]           wid_i,
  input  logic [PayW-1:0]          wpay_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [IdW-1:0]           rid_o,
  output logic [PayW-1:0]          rpay_o
);

  logic [IdW-1:0]  id_mem  [Depth];
  logic [PayW-1:0] pay_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      id_mem[waddr_i]  <= wid_i;
      pay_mem[waddr_i] <= wpay_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rid_o  <= id_mem[raddr_i];
    rpay_o <= pay_mem[raddr_i];
  end

endmodule

### rtl/core/krt_seq.sv
module krt_seq #(
  parameter int unsigned Capacity = 16,
  parameter int unsigned IdW      = 16,
  parameter int unsigned PayW     = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request side
  input  logic                             req_valid_i,
  output logic                             busy_o,
  input  krt_pkg::kind_e                   kind_i,
  input  logic [IdW-1:0]                   key_i,
  input  logic [PayW-1:0]                  pay_i,
  // result side
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output krt_pkg::status_e                 status_o,
  output logic [$clog2(Capacity+1)-1:0]    count_o,
  output logic [IdW-1:0]                   fid_o,
  output logic [PayW-1:0]                  fpay_o,
  // record memory
  output logic                             mem_we_o,
  output logic [$clog2(Capacity)-1:0]      mem_waddr_o,
  output logic [IdW-1:0]                   mem_wid_o,
  output logic [PayW-1:0]                  mem_wpay_o,
  output logic [$clog2(Capacity)-1:0]      mem_raddr_o,
  input  logic [IdW-1:0]                   mem_rid_i,
  input  logic [PayW-1:0]                  mem_rpay_i
);

  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned CntW  = $clog2(Capacity + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REPLY
  } state_e;

  state_e           state_q, state_d;
  krt_pkg::kind_e   op_q, op_d;
  logic [IdW-1:0]   key_q, key_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  rd_q, rd_d;     // next slot to read
  logic [CntW-1:0]  wr_q, wr_d;     // next compacted slot
  logic             vld_q, vld_d;   // read data holds slot rd_q-1
  krt_pkg::status_e status_q, status_d;
  logic [IdW-1:0]   fid_q, fid_d;
  logic [PayW-1:0]  fpay_q, fpay_d;
  logic             match;

  assign match = (mem_rid_i == key_q);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    count_d     = count_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    vld_d       = 1'b0;
    status_d    = status_q;
    fid_d       = fid_q;
    fpay_d      = fpay_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = wr_q[AddrW-1:0];
    mem_wid_o   = mem_rid_i;
    mem_wpay_o  = mem_rpay_i;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_d    = kind_i;
          key_d   = key_i;
          fid_d   = '0;
          fpay_d  = '0;
          rd_d    = '0;
          wr_d    = '0;
          state_d = S_REPLY;
          unique case (kind_i)
            krt_pkg::KIND_ADD: begin
              if (count_q < CntW'(Capacity)) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = count_q[AddrW-1:0];
                mem_wid_o   = key_i;
                mem_wpay_o  = pay_i;
                count_d     = count_q + CntW'(1);
                status_d    = krt_pkg::ST_DONE;
              end else begin
                status_d = krt_pkg::ST_REJECTED;
              end
            end
            krt_pkg::KIND_REMOVE: begin
              if (count_q == '0) begin
                status_d = krt_pkg::ST_REJECTED;
              end else begin
                state_d = S_SCAN;
              end
            end
            krt_pkg::KIND_FIND: begin
              if (count_q == '0) begin
                status_d = krt_pkg::ST_NOT_FOUND;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: begin
              status_d = krt_pkg::ST_REJECTED;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (rd_q != count_q) begin
          rd_d  = rd_q + CntW'(1);
          vld_d = 1'b1;
        end
        if (vld_q) begin
          if (op_q == krt_pkg::KIND_FIND) begin
            if (match) begin
              status_d = krt_pkg::ST_FOUND;
              fid_d    = mem_rid_i;
              fpay_d   = mem_rpay_i;
              state_d  = S_REPLY;
            end
          end else if (!match) begin
            // survivor moves down to the compacted slot
            mem_we_o = 1'b1;
            wr_d     = wr_q + CntW'(1);
          end
        end else if (rd_q == count_q) begin
          if (op_q == krt_pkg::KIND_FIND) begin
            status_d = krt_pkg::ST_NOT_FOUND;
          end else begin
            status_d = krt_pkg::ST_DONE;
            count_d  = wr_q;
          end
          state_d = S_REPLY;
        end
      end

      S_REPLY: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      vld_q    <= 1'b0;
      rd_q     <= '0;
      wr_q     <= '0;
      op_q     <= krt_pkg::KIND_ADD;
      status_q <= krt_pkg::ST_DONE;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      vld_q    <= vld_d;
      rd_q     <= rd_d;
      wr_q     <= wr_d;
      op_q     <= op_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    fid_q  <= fid_d;
    fpay_q <= fpay_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_REPLY);
  assign status_o    = status_q;
  assign count_o     = count_q;
  assign fid_o       = fid_q;
  assign fpay_o      = fpay_q;
  assign mem_raddr_o = rd_q[AddrW-1:0];

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("record count above capacity");

  a_compact_behind_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (wr_q <= rd_q && rd_q <= count_q))
    else $error("scan pointers out of order");

  a_scan_enters_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && state_d == S_SCAN) |=> (!vld_q && rd_q == '0 && wr_q == '0))
    else $error("scan started with stale pointers");

  a_reply_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ready_i) |=> (res_valid_o && $stable(status_q)
                                       && $stable(count_q)))
    else $error("pending result changed");

  a_count_only_on_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REPLY) |=> $stable(count_q))
    else $error("count changed without an operation");
`endif

endmodule

### rtl/core/keyed_record_table.sv
// Keyed record table. Holds up to CAPACITY records (an id of ID_BITS bits and
// a payload of PAYLOAD_BITS bits), packed in insertion order. kind_i selects
// add (append, rejected when full), remove (drop every record with the id and
// close the gaps in order; rejected when empty, done with no change when the
// id is absent) or find (first record with the id, else not found); the
// unused kind is rejected. Every input transfer yields exactly one output
// transfer carrying status, the record count after the operation and, for a
// hit, the found record (zeros otherwise). Ids wider than the port are used
// at port width. One operation is in flight at a time: in_stall_o is high
// from the accepting edge until its result has moved into the output
// register. Add goes from accept to the reply state, then into the output
// register. Remove and find walk the stored records through one compare
// unit behind the single read port of the record memory, one record per
// cycle; a find that hits ends the walk early. A finished result waits in
// the output register, so the next transfer is taken while it is still
// stalled. The record memory needs no clearing after reset: only data read
// from slots below the count is ever used.
module keyed_record_table #(
  parameter int unsigned CAPACITY     = 16,
  parameter int unsigned PAYLOAD_BITS = 64,
  parameter int unsigned ID_BITS      = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [krt_pkg::KindW-1:0]           kind_i,
  input  logic [krt_pkg::IdPortW-1:0]         entry_id_i,
  input  logic [krt_pkg::PayPortW-1:0]        entry_payload_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [krt_pkg::StatusW-1:0]         status_o,
  output logic [krt_pkg::CountW-1:0]          count_now_o,
  output logic [krt_pkg::IdPortW-1:0]         found_id_o,
  output logic [krt_pkg::PayPortW-1:0]        found_payload_o
);

  // Ids are used at the narrower of the stored and port widths.
  localparam int unsigned IdW   = (ID_BITS < krt_pkg::IdPortW) ? ID_BITS : krt_pkg::IdPortW;
  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  logic                     busy;
  logic                     req_valid;
  logic                     res_valid;
  logic                     res_ready;
  krt_pkg::status_e         res_status;
  logic [CntW-1:0]          res_count;
  logic [IdW-1:0]           res_fid;
  logic [PAYLOAD_BITS-1:0]  res_fpay;

  logic                     mem_we;
  logic [AddrW-1:0]         mem_waddr;
  logic [IdW-1:0]           mem_wid;
  logic [PAYLOAD_BITS-1:0]  mem_wpay;
  logic [AddrW-1:0]         mem_raddr;
  logic [IdW-1:0]           mem_rid;
  logic [PAYLOAD_BITS-1:0]  mem_rpay;

  // output register
  logic                     out_valid_q, out_valid_d;
  krt_pkg::status_e         status_q;
  logic [CntW-1:0]          count_q;
  logic [IdW-1:0]           fid_q;
  logic [PAYLOAD_BITS-1:0]  fpay_q;

  assign in_stall_o = busy;
  assign req_valid  = in_valid_i & ~busy;

  // The result moves out of the sequencer once the output register is free
  // or is being emptied in this cycle.
  assign res_ready  = ~out_valid_q | ~out_stall_i;

  krt_seq #(
    .Capacity (CAPACITY),
    .IdW      (IdW),
    .PayW     (PAYLOAD_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .busy_o      (busy),
    .kind_i      (krt_pkg::kind_e'(kind_i)),
    .key_i       (entry_id_i[IdW-1:0]),
    .pay_i       (entry_payload_i[PAYLOAD_BITS-1:0]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .status_o    (res_status),
    .count_o     (res_count),
    .fid_o       (res_fid),
    .fpay_o      (res_fpay),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wid_o   (mem_wid),
    .mem_wpay_o  (mem_wpay),
    .mem_raddr_o (mem_raddr),
    .mem_rid_i   (mem_rid),
    .mem_rpay_i  (mem_rpay)
  );

  krt_mem #(
    .Depth (CAPACITY),
    .IdW   (IdW),
    .PayW  (PAYLOAD_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wid_i   (mem_wid),
    .wpay_i  (mem_wpay),
    .raddr_i (mem_raddr),
    .rid_o   (mem_rid),
    .rpay_o  (mem_rpay)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      status_q <= res_status;
      count_q  <= res_count;
      fid_q    <= res_fid;
      fpay_q   <= res_fpay;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign count_now_o     = krt_pkg::CountW'(count_q);
  assign found_id_o      = krt_pkg::IdPortW'(fid_q);
  assign found_payload_o = krt_pkg::PayPortW'(fpay_q);

endmodule

### dv/tb_keyed_record_table.sv
`timescale 1ns / 100ps

module tb_keyed_record_table;
  import krt_pkg::*;

  localparam int unsigned Capacity   = 16;
  localparam int unsigned CycleLimit = 500_000;
  localparam int unsigned RandomOps  = 1525;
  // kind value with no operation behind it; the table must reject it
  localparam logic [KindW-1:0] KindUnused = 2'd3;

  // one result transfer as the table should produce it
  typedef struct {
    status_e               status;
    logic [CountW-1:0]     count;
    logic [IdPortW-1:0]    id;
    logic [PayPortW-1:0]   payload;
  } table_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [KindW-1:0]      kind_i = '0;
  logic [IdPortW-1:0]    entry_id_i = '0;
  logic [PayPortW-1:0]   entry_payload_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [StatusW-1:0]    status_o;
  logic [CountW-1:0]     count_now_o;
  logic [IdPortW-1:0]    found_id_o;
  logic [PayPortW-1:0]   found_payload_o;

  // shadow copy of the table contents, packed in insertion order
  logic [IdPortW-1:0]    shadow_ids [Capacity];
  logic [PayPortW-1:0]   shadow_payloads [Capacity];
  int unsigned           shadow_count;

  table_result_t         pending_results[$];
  int unsigned           error_count;
  int unsigned           cycle_count;
  // high while neither side idles nor stalls
  bit                    quiet;

  keyed_record_table u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .entry_id_i      (entry_id_i),
    .entry_payload_i (entry_payload_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .count_now_o     (count_now_o),
    .found_id_o      (found_id_o),
    .found_payload_o (found_payload_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop: a hung handshake or a lost result ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Applies one operation to the shadow table and returns the result it
  // should give. Remove keeps survivors in order by copying each one down
  // to the next free slot.
  function automatic table_result_t table_outcome(logic [KindW-1:0] kind,
                                                  logic [IdPortW-1:0] key,
                                                  logic [PayPortW-1:0] payload);
    table_result_t res;
    int unsigned   wr;
    res = '{status: ST_REJECTED, count: '0, id: '0, payload: '0};
    wr  = 0;
    case (kind)
      KIND_ADD: begin
        if (shadow_count < Capacity) begin
          shadow_ids[shadow_count]      = key;
          shadow_payloads[shadow_count] = payload;
          shadow_count++;
          res.status = ST_DONE;
        end
      end
      KIND_REMOVE: begin
        if (shadow_count > 0) begin
          for (int unsigned rd = 0; rd < shadow_count; rd++) begin
            if (shadow_ids[rd] != key) begin
              shadow_ids[wr]      = shadow_ids[rd];
              shadow_payloads[wr] = shadow_payloads[rd];
              wr++;
            end
          end
          shadow_count = wr;
          res.status   = ST_DONE;
        end
      end
      KIND_FIND: begin
        res.status = ST_NOT_FOUND;
        for (int unsigned rd = 0; rd < shadow_count; rd++) begin
          if (shadow_ids[rd] == key) begin
            res.status  = ST_FOUND;
            res.id      = shadow_ids[rd];
            res.payload = shadow_payloads[rd];
            break;
          end
        end
      end
      default: ;  // unused kind: rejected, table untouched
    endcase
    res.count = shadow_count[CountW-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    error_count++;
    $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Sends one operation. Called and returns just after a falling edge, with
  // no assignment to in_valid_i made in that step, so valid stays high
  // across back-to-back transfers.
  task automatic send_op(logic [KindW-1:0] kind, logic [IdPortW-1:0] key,
                         logic [PayPortW-1:0] payload);
    while (!quiet && $urandom_range(99) < 26) begin
      in_valid_i <= 1'b0;
      kind_i          <= KindW'($urandom);
      entry_id_i      <= IdPortW'($urandom);
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= kind;
    entry_id_i      <= key;
    entry_payload_i <= payload;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(table_outcome(kind, key, payload));
    @(negedge clk_i);
  endtask

  // Sender holds off until every pending result has come back.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // Receiver stalls at random on the falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < 26);
  end

  // Every output transfer is checked against the oldest expectation.
  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", status_o, '0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (count_now_o !== want.count) report_mismatch("count_now", count_now_o, want.count);
        if (found_id_o !== want.id) report_mismatch("found_id", found_id_o, want.id);
        if (found_payload_o !== want.payload) begin
          report_mismatch("found_payload", found_payload_o, want.payload);
        end
      end
    end
  end

  // Empty table: remove is rejected, find misses, the unused kind is rejected.
  task automatic test_empty_table();
    send_op(KIND_REMOVE, 16'h0000, 64'h0);
    send_op(KIND_FIND, 16'hFFFF, 64'h0);
    send_op(KindUnused, 16'hA5A5, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  // Fill to capacity with extreme ids and payloads, then one add too many.
  // Odd slots all carry id FFFF so a later remove hits many records.
  task automatic test_fill_to_full();
    logic [IdPortW-1:0]  key;
    logic [PayPortW-1:0] payload;
    for (int unsigned slot = 0; slot < Capacity; slot++) begin
      key     = slot[0] ? 16'hFFFF : IdPortW'(slot);
      payload = slot[0] ? 64'(slot) : ~64'(slot);
      send_op(KIND_ADD, key, payload);
    end
    send_op(KIND_ADD, 16'h1234, 64'hDEAD_BEEF_0000_0001);
  endtask

  // Find the first of duplicates, miss, remove a duplicated id with
  // compaction, remove an absent id, then find a survivor.
  task automatic test_remove_and_find();
    send_op(KIND_FIND, 16'hFFFF, 64'h0);
    send_op(KIND_FIND, 16'h5555, 64'h0);
    send_op(KIND_REMOVE, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(KIND_REMOVE, 16'h5555, 64'h0);
    send_op(KIND_FIND, 16'h000E, 64'h0);
  endtask

  // Random traffic. Ids mostly come from a small pool so finds and removes
  // hit; the add share drifts per block of items so the table swings
  // between empty and full.
  task automatic test_random_traffic();
    int unsigned         add_pct;
    int unsigned         roll;
    logic [KindW-1:0]    kind;
    logic [IdPortW-1:0]  key;
    logic [PayPortW-1:0] payload;
    add_pct = 50;
    for (int unsigned n = 0; n < RandomOps; n++) begin
      if (n % 80 == 0) add_pct = $urandom_range(75, 25);
      quiet = (n >= 600 && n < 800);
      if (n == 1000) wait_for_drain();
      roll = $urandom_range(99);
      if (roll < add_pct) kind = KIND_ADD;
      else if (roll < add_pct + (100 - add_pct) / 2) kind = KIND_FIND;
      else if (roll < 96) kind = KIND_REMOVE;
      else kind = KindUnused;
      key     = ($urandom_range(99) < 75) ? IdPortW'($urandom_range(7)) : IdPortW'($urandom);
      payload = {$urandom, $urandom};
      send_op(kind, key, payload);
    end
    quiet = 1'b0;
  endtask

  initial begin
    shadow_count = 0;
    quiet        = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_table();
    test_fill_to_full();
    test_remove_and_find();
    test_random_traffic();

    // let the last results come home, then allow a full scan for strays
    wait_for_drain();
    repeat (40) @(negedge clk_i);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
